>>> design/bgp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCH generator polynomial builder package
// Field types, GF(64) arithmetic, power table and shared control types.
// ----------------------------------------------------------------------------
package bgp_pkg;

    localparam int GF_W     = 6;
    localparam int IDX_W    = 4;
    localparam int WORD_W   = 32;
    localparam int CNT_W    = 5;
    localparam int N_ENTRY  = 16;
    localparam int STEP_CNT = 4;

    typedef logic [GF_W-1:0]   t_gf;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Primitive polynomial x^6 + x + 1.
    localparam logic [GF_W:0] GF_POLY = 7'd67;

    localparam t_idx LAST_IDX = t_idx'(N_ENTRY - 1);

    // Powers of alpha; exponent 63 wraps back to alpha^0.
    localparam t_gf ALPHA_POW [64] = '{
        6'd1,  6'd2,  6'd4,  6'd8,  6'd16, 6'd32, 6'd3,  6'd6,
        6'd12, 6'd24, 6'd48, 6'd35, 6'd5,  6'd10, 6'd20, 6'd40,
        6'd19, 6'd38, 6'd15, 6'd30, 6'd60, 6'd59, 6'd53, 6'd41,
        6'd17, 6'd34, 6'd7,  6'd14, 6'd28, 6'd56, 6'd51, 6'd37,
        6'd9,  6'd18, 6'd36, 6'd11, 6'd22, 6'd44, 6'd27, 6'd54,
        6'd47, 6'd29, 6'd58, 6'd55, 6'd45, 6'd25, 6'd50, 6'd39,
        6'd13, 6'd26, 6'd52, 6'd43, 6'd21, 6'd42, 6'd23, 6'd46,
        6'd31, 6'd62, 6'd63, 6'd61, 6'd57, 6'd49, 6'd33, 6'd1
    };

    // Control broadcast from the top level to every coefficient cell.
    typedef struct packed {
        logic load;   // a request is accepted this cycle
        logic clear;  // polynomial returns to one before the root is applied
        logic apply;  // the root is multiplied in (capacity not yet reached)
    } t_cell_ctrl;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // Shift-and-add multiply in GF(64) with reduction by the field polynomial.
    function automatic t_gf gf_mul(t_gf a, t_gf b);
        logic [GF_W:0] x;
        t_gf           acc;
        acc = '0;
        x   = {1'b0, a};
        for (int k = 0; k < GF_W; k++) begin
            if (b[k]) begin
                acc = acc ^ x[GF_W-1:0];
            end
            x = {x[GF_W-1:0], 1'b0};
            if (x[GF_W]) begin
                x = x ^ GF_POLY;
            end
        end
        return acc;
    endfunction

endpackage

>>> design/bgp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCH generator coefficient cell
// Holds one coefficient and updates it as lower ^ coef * root.
// ----------------------------------------------------------------------------
module bgp_cell #(
    parameter bit RESET_ONE = 1'b0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bgp_pkg::t_cell_ctrl i_ctrl,
    input  bgp_pkg::t_gf        i_root,
    input  bgp_pkg::t_gf        i_lower,
    output bgp_pkg::t_gf        o_eff
);
    import bgp_pkg::*;

    localparam t_gf RESET_VAL = RESET_ONE ? t_gf'(1) : t_gf'(0);

    t_gf r_coef;
    t_gf n_coef;

    // The coefficient as seen by this request, after an optional restart.
    assign o_eff = i_ctrl.clear ? RESET_VAL : r_coef;

    always_comb begin
        n_coef = r_coef;
        if (i_ctrl.load) begin
            n_coef = i_ctrl.apply ? (i_lower ^ gf_mul(o_eff, i_root)) : o_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= RESET_VAL;
        end else begin
            r_coef <= n_coef;
        end
    end

endmodule

>>> design/bch_generator_polynomial_builder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCH generator polynomial builder
// Multiplies a GF(64) polynomial by (x + alpha^e) per request and emits the
// 16-entry LFSR step table of the packed generator on a final request.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start high and busy low. A request
// without final_root leaves busy low, so such roots can arrive back to back.
// A request with final_root raises busy after the edge that accepts it; the
// sixteen table results follow, one per cycle, with the first shown in the
// cycle after busy rises, each marked by o_result_valid for a single cycle.
// The receiver cannot stall the result stream, so it must take each result
// in the cycle it is shown. The last result is taken at the same edge that
// can accept the next request, so a final request holds off further
// requests until the one-entry-per-cycle table emitter has shown every entry.
// ----------------------------------------------------------------------------
module bch_generator_polynomial_builder_unit #(
    parameter int MAX_ROOTS  = 18,
    parameter int PACK_SHIFT = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [5:0]           i_root_exponent,
    input  logic                 i_restart,
    input  logic                 i_final_root,
    output logic                 o_result_valid,
    output bgp_pkg::t_idx        o_table_index,
    output bgp_pkg::t_word       o_step_word,
    output bgp_pkg::t_word       o_generator_word,
    output logic                 o_too_many_roots,
    output logic                 o_last_entry
);
    import bgp_pkg::*;

    // One cell per coefficient of a degree MAX_ROOTS polynomial.
    localparam int NCOEF = MAX_ROOTS + 1;

    // Shift register step table entry: index at the top, four LFSR steps.
    function automatic t_word step_entry(t_idx v, t_word gen);
        t_word s;
        s = {v, {(WORD_W - IDX_W){1'b0}}};
        for (int k = 0; k < STEP_CNT; k++) begin
            s = s[WORD_W-1] ? ({s[WORD_W-2:0], 1'b0} ^ gen) : {s[WORD_W-2:0], 1'b0};
        end
        return s;
    endfunction

    t_state     r_state;
    t_state     n_state;
    t_cnt       r_roots;
    t_cnt       n_roots;
    logic       r_ovf;
    logic       n_ovf;
    t_idx       r_idx;
    t_idx       n_idx;
    logic       r_valid;
    t_idx       r_out_idx;
    t_word      r_out_step;
    t_word      r_out_gen;
    logic       r_out_ovf;
    logic       r_out_last;

    logic       accept;
    logic       emit;
    t_cnt       eff_roots;
    logic       eff_ovf;
    t_cell_ctrl ctrl;
    t_gf        root;
    t_gf        eff [NCOEF];
    t_word      gen_word;

    assign accept = start && !busy;

    // Restart hides the stored count and flag from this request.
    assign eff_roots = i_restart ? '0 : r_roots;
    assign eff_ovf   = i_restart ? 1'b0 : r_ovf;

    // The clear only acts on an accepted request, so a waiting request with
    // restart set cannot disturb the generator while the table is emitted.
    assign ctrl.load  = accept;
    assign ctrl.clear = accept && i_restart;
    assign ctrl.apply = eff_roots < t_cnt'(MAX_ROOTS);

    assign root = ALPHA_POW[i_root_exponent];

    always_comb begin
        n_roots = r_roots;
        n_ovf   = r_ovf;
        if (accept) begin
            n_roots = ctrl.apply ? (eff_roots + t_cnt'(1)) : eff_roots;
            n_ovf   = ctrl.apply ? eff_ovf : 1'b1;
        end
    end

    // Row of coefficient cells; each cell passes its current value up to the
    // next higher cell, which uses it as the x * g(x) term.
    genvar gi;
    generate
        for (gi = 0; gi < NCOEF; gi++) begin : g_cell
            t_gf lower;
            if (gi == 0) begin : g_first
                assign lower = '0;
            end else begin : g_rest
                assign lower = eff[gi-1];
            end
            bgp_cell #(
                .RESET_ONE (gi == 0)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (ctrl),
                .i_root  (root),
                .i_lower (lower),
                .o_eff   (eff[gi])
            );
        end

        // Pack coefficients 0..MAX_ROOTS-1; positions past the word drop out.
        for (gi = 0; gi < WORD_W; gi++) begin : g_pack
            if (gi >= PACK_SHIFT && gi - PACK_SHIFT < MAX_ROOTS) begin : g_bit
                assign gen_word[gi] = (eff[gi - PACK_SHIFT] != '0);
            end else begin : g_zero
                assign gen_word[gi] = 1'b0;
            end
        end
    endgenerate

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_final_root) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        busy = 1'b0;
        emit = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                emit = 1'b0;
            end
            ST_EMIT: begin
                busy = 1'b1;
                emit = 1'b1;
            end
            default: begin
                busy = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    assign n_idx = emit ? (r_idx + t_idx'(1)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_roots <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_roots <= n_roots;
            r_ovf   <= n_ovf;
            r_idx   <= n_idx;
            r_valid <= emit;
        end
    end

    // Result register; the polynomial is frozen while entries are emitted.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_idx  <= r_idx;
            r_out_step <= step_entry(r_idx, gen_word);
            r_out_gen  <= gen_word;
            r_out_ovf  <= r_ovf;
            r_out_last <= (r_idx == LAST_IDX);
        end
    end

    assign o_result_valid   = r_valid;
    assign o_table_index    = r_out_idx;
    assign o_step_word      = r_out_step;
    assign o_generator_word = r_out_gen;
    assign o_too_many_roots = r_out_ovf;
    assign o_last_entry     = r_out_last;

endmodule
